// ===== rtl/rdq_pkg.sv =====
// shared constants, codes and types of the reversible deque
package rdq_pkg;

  localparam int DEPTH = 1024;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int WORD_W = 32;
  localparam int OP_W = 3;
  localparam int STATUS_W = 2;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_TOGGLE     = 3'd4;

  localparam logic [STATUS_W-1:0] ST_NONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_VALID = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

  localparam logic [1:0] KIND_NOP  = 2'd0;
  localparam logic [1:0] KIND_PUSH = 2'd1;
  localparam logic [1:0] KIND_POP  = 2'd2;

  // physical command handed from the front part to the back part
  typedef struct packed {
    logic [1:0]               kind;
    logic                     at_front;
    logic signed [WORD_W-1:0] value;
  } cmd_t;

endpackage

// ===== rtl/rdq_in_if.sv =====
// request channel of the reversible deque
interface rdq_in_if;
  logic                              valid;
  logic                              ready;
  logic [rdq_pkg::OP_W-1:0]          op;
  logic signed [rdq_pkg::WORD_W-1:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink (input valid, input op, input value, output ready);
endinterface

// ===== rtl/rdq_out_if.sv =====
// response channel of the reversible deque
interface rdq_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [rdq_pkg::WORD_W-1:0] popped;
  logic [rdq_pkg::STATUS_W-1:0]      status;

  modport source (output valid, output popped, output status, input ready);
  modport sink (input valid, input popped, input status, output ready);
endinterface

// ===== rtl/rdq_front.sv =====
// front part: accepts requests, keeps the reverse flag, maps ops to physical commands
module rdq_front (
  input  logic          clk,
  input  logic          rst,
  rdq_in_if.sink        req,
  output logic          q_valid,
  output rdq_pkg::cmd_t q_cmd,
  input  logic          q_ready
);

  logic reversed;
  logic accept;

  assign req.ready = q_ready;
  assign q_valid   = req.valid;
  assign accept    = req.valid && q_ready;

  always_comb begin
    q_cmd.kind     = rdq_pkg::KIND_NOP;
    q_cmd.at_front = 1'b0;
    q_cmd.value    = req.value;
    unique case (req.op)
      rdq_pkg::OP_PUSH_FRONT: begin
        q_cmd.kind     = rdq_pkg::KIND_PUSH;
        q_cmd.at_front = !reversed;
      end
      rdq_pkg::OP_PUSH_BACK: begin
        q_cmd.kind     = rdq_pkg::KIND_PUSH;
        q_cmd.at_front = reversed;
      end
      rdq_pkg::OP_POP_FRONT: begin
        q_cmd.kind     = rdq_pkg::KIND_POP;
        q_cmd.at_front = !reversed;
      end
      rdq_pkg::OP_POP_BACK: begin
        q_cmd.kind     = rdq_pkg::KIND_POP;
        q_cmd.at_front = reversed;
      end
      default: begin
        // toggle and unused codes give a plain done result
        q_cmd.kind = rdq_pkg::KIND_NOP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reversed <= 1'b0;
    end else if (accept && req.op == rdq_pkg::OP_TOGGLE) begin
      reversed <= !reversed;
    end
  end

endmodule

// ===== rtl/rdq_cmd_fifo.sv =====
// two-entry command queue between front and back
module rdq_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  rdq_pkg::cmd_t wr_cmd,
  output logic          rd_valid,
  input  logic          rd_ready,
  output rdq_pkg::cmd_t rd_cmd
);

  rdq_pkg::cmd_t slots [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    fill;
  logic          do_wr;
  logic          do_rd;

  assign wr_ready = (fill != 2'd2);
  assign rd_valid = (fill != 2'd0);
  assign rd_cmd   = slots[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_rd) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_wr && !do_rd) begin
        fill <= fill + 2'd1;
      end else if (do_rd && !do_wr) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

endmodule

// ===== rtl/rdq_back.sv =====
// back part: ring store, head and count, result register
module rdq_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  rdq_pkg::cmd_t cmd,
  rdq_out_if.source     rsp
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic signed [rdq_pkg::WORD_W-1:0] ring [rdq_pkg::DEPTH];
  logic signed [rdq_pkg::WORD_W-1:0] rd_data;
  logic signed [rdq_pkg::WORD_W-1:0] popped;
  logic [rdq_pkg::STATUS_W-1:0]      status;
  logic [rdq_pkg::IDX_W-1:0]         head;
  logic [rdq_pkg::CNT_W-1:0]         count;
  logic                              state;
  logic                              out_valid;

  logic [rdq_pkg::IDX_W-1:0] head_dec;
  logic [rdq_pkg::IDX_W-1:0] head_inc;
  logic [rdq_pkg::IDX_W-1:0] tail_idx;
  logic [rdq_pkg::IDX_W-1:0] last_idx;
  logic [rdq_pkg::IDX_W-1:0] rd_addr;
  logic                      full;
  logic                      empty;
  logic                      take;
  logic                      push_ok;
  logic                      pop_ok;
  logic                      load_now;

  assign rsp.valid  = out_valid;
  assign rsp.popped = popped;
  assign rsp.status = status;

  // ring wraps by truncation of the index
  assign head_dec = head - rdq_pkg::IDX_W'(1);
  assign head_inc = head + rdq_pkg::IDX_W'(1);
  assign tail_idx = head + count[rdq_pkg::IDX_W-1:0];
  assign last_idx = tail_idx - rdq_pkg::IDX_W'(1);
  assign rd_addr  = cmd.at_front ? head : last_idx;

  assign full  = (count == rdq_pkg::CNT_W'(rdq_pkg::DEPTH));
  assign empty = (count == '0);

  assign cmd_ready = (state == S_IDLE) && (!out_valid || rsp.ready);
  assign take      = cmd_valid && cmd_ready;
  assign push_ok   = take && cmd.kind == rdq_pkg::KIND_PUSH && !full;
  assign pop_ok    = take && cmd.kind == rdq_pkg::KIND_POP && !empty;
  // every taken command but a good pop gives its result right away
  assign load_now  = take && !pop_ok;

  always_ff @(posedge clk) begin
    if (push_ok) begin
      if (cmd.at_front) begin
        ring[head_dec] <= cmd.value;
      end else begin
        ring[tail_idx] <= cmd.value;
      end
    end
    rd_data <= ring[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_READ) begin
        out_valid <= 1'b1;
        state     <= S_IDLE;
      end else if (load_now) begin
        out_valid <= 1'b1;
      end else begin
        if (pop_ok) begin
          state <= S_READ;
        end
        if (rsp.ready) begin
          out_valid <= 1'b0;
        end
      end
      if (push_ok) begin
        count <= count + rdq_pkg::CNT_W'(1);
        if (cmd.at_front) begin
          head <= head_dec;
        end
      end else if (pop_ok) begin
        count <= count - rdq_pkg::CNT_W'(1);
        if (cmd.at_front) begin
          head <= head_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      popped <= rd_data;
      status <= rdq_pkg::ST_VALID;
    end else if (load_now) begin
      popped <= '0;
      if (cmd.kind == rdq_pkg::KIND_PUSH && full) begin
        status <= rdq_pkg::ST_FULL;
      end else if (cmd.kind == rdq_pkg::KIND_POP) begin
        status <= rdq_pkg::ST_EMPTY;
      end else begin
        status <= rdq_pkg::ST_NONE;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= rdq_pkg::CNT_W'(rdq_pkg::DEPTH))
    else $error("entry count above depth");

  a_read_slot_free: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |-> !out_valid)
    else $error("result register busy during pop read");

  a_pop_then_result: assert property (@(posedge clk) disable iff (rst)
    pop_ok |=> state == S_READ && count == $past(count) - rdq_pkg::CNT_W'(1))
    else $error("pop did not start a read");

  a_zero_without_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != rdq_pkg::ST_VALID |-> popped == '0)
    else $error("nonzero word on a result without data");
`endif

endmodule

// ===== rtl/reversible_deque.sv =====
// top level of the reversible double-ended queue
//
// channel  dir  fields                       word accepted when
// req      in   op[2:0], value[31:0] signed  req.valid && req.ready
// rsp      out  popped[31:0] signed, status  rsp.valid && rsp.ready
//
// a push, toggle or rejected op goes to the result register directly, a good
// pop via one registered read of the ring store, then the result register
// the 2-entry command queue lets requests enter while the back part works
// or while a result waits on rsp
// rst is synchronous and clears head, count, reverse flag and queues; the
// ring store is not cleared, only occupied entries reach rsp as popped data
module reversible_deque (
  input  logic      clk,
  input  logic      rst,
  rdq_in_if.sink    req,
  rdq_out_if.source rsp
);

  // front to queue
  logic          f_valid;
  logic          f_ready;
  rdq_pkg::cmd_t f_cmd;

  // queue to back
  logic          b_valid;
  logic          b_ready;
  rdq_pkg::cmd_t b_cmd;

  // classify op against the reverse flag into a physical end
  rdq_front u_front (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .q_valid (f_valid),
    .q_cmd   (f_cmd),
    .q_ready (f_ready)
  );

  // decouples classification from execution
  rdq_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_cmd   (f_cmd),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_cmd   (b_cmd)
  );

  // ring store, pointers, full/empty checks and the result register
  rdq_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (b_valid),
    .cmd_ready (b_ready),
    .cmd       (b_cmd),
    .rsp       (rsp)
  );

endmodule
